// ===== design/slce_pkg.sv =====
// ----------------------------------------------------------------------------
// slce_pkg
// Shared types and constants for the serial command line editor.
// ----------------------------------------------------------------------------
package slce_pkg;

    localparam int LINE_LEN    = 32;
    localparam int CNT_W       = $clog2(LINE_LEN + 1);
    localparam int ADDR_W      = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int TDATA_W     = 24;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_LOW  = 8'h20;
    localparam logic [7:0] CH_HIGH = 8'h7E;

    // byte class decided by the front end
    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_PRINT = 2'd1,
        CLS_CR    = 2'd2,
        CLS_BS    = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [6:0] ch;
    } cmd_t;

    // first member in the highest bits, so echo_valid lands in bit 0
    typedef struct packed {
        logic       overflow;
        logic       line_end;
        logic [6:0] line_byte;
        logic       line_valid;
        logic [7:0] echo_byte;
        logic       echo_valid;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== design/slce_front.sv =====
// ----------------------------------------------------------------------------
// slce_front
// Accepts received bytes and classifies them into editor commands.
// ----------------------------------------------------------------------------
module slce_front (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    input  logic             q_full,
    output logic             push,
    output slce_pkg::cmd_t   push_cmd
);
    import slce_pkg::*;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_cmd.ch = s_tdata[6:0];
        if (s_tdata == CH_CR) begin
            push_cmd.cls = CLS_CR;
        end else if (s_tdata == CH_BS) begin
            push_cmd.cls = CLS_BS;
        end else if (s_tdata inside {[CH_LOW:CH_HIGH]}) begin
            push_cmd.cls = CLS_PRINT;
        end else begin
            push_cmd.cls = CLS_OTHER;
        end
    end

endmodule

// ===== design/slce_queue.sv =====
// ----------------------------------------------------------------------------
// slce_queue
// Short command queue between the front end and the line engine.
// ----------------------------------------------------------------------------
module slce_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  slce_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output slce_pkg::cmd_t  head_cmd
);
    import slce_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    fill_reg, fill_next;

    assign full       = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("slce_queue: push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> !pop)
        else $error("slce_queue: pop from empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("slce_queue: fill count did not follow a push");

endmodule

// ===== design/slce_back.sv =====
// ----------------------------------------------------------------------------
// slce_back
// Line engine: holds the line, carries out commands, drives the results.
// ----------------------------------------------------------------------------
module slce_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  slce_pkg::cmd_t                head_cmd,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [slce_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import slce_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CR   = 5'b00010,
        S_DUMP = 5'b00100,
        S_BS1  = 5'b01000,
        S_BS2  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;

    logic [6:0]         line_mem [LINE_LEN];
    logic [6:0]         rd_data_reg;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    logic               out_valid_reg;
    result_t            out_data_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               emit;
    result_t            res;
    logic               res_last;
    logic               dump_fin;

    assign out_free = !out_valid_reg || m_tready;
    assign dump_fin = ({1'b0, idx_reg} + 1'b1) == (ADDR_W + 1)'(count_reg);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        res        = '0;
        res_last   = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_reg + 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (head_valid && out_free) begin
                    pop = 1'b1;
                    case (head_cmd.cls)
                        CLS_CR: begin
                            emit           = 1'b1;
                            res.echo_valid = 1'b1;
                            res.echo_byte  = CH_LF;
                            // prefetch the first character
                            rd_en          = 1'b1;
                            rd_addr        = '0;
                            state_next     = S_CR;
                        end
                        CLS_BS: begin
                            if (count_reg != '0) begin
                                emit           = 1'b1;
                                res.echo_valid = 1'b1;
                                res.echo_byte  = CH_BS;
                                count_next     = count_reg - 1'b1;
                                state_next     = S_BS1;
                            end
                        end
                        default: begin
                            if (count_reg >= CNT_W'(LINE_LEN)) begin
                                emit         = 1'b1;
                                res.overflow = 1'b1;
                                res_last     = 1'b1;
                                count_next   = '0;
                            end else if (head_cmd.cls == CLS_PRINT) begin
                                wr_en          = 1'b1;
                                emit           = 1'b1;
                                res.echo_valid = 1'b1;
                                res.echo_byte  = {1'b0, head_cmd.ch};
                                res_last       = 1'b1;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_CR: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.echo_valid = 1'b1;
                    res.echo_byte  = CH_CR;
                    if (count_reg == '0) begin
                        res.line_end = 1'b1;
                        res_last     = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        idx_next   = '0;
                        state_next = S_DUMP;
                    end
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.line_valid = 1'b1;
                    res.line_byte  = rd_data_reg;
                    rd_en          = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    if (dump_fin) begin
                        res.line_end = 1'b1;
                        res_last     = 1'b1;
                        count_next   = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_BS1: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.echo_valid = 1'b1;
                    res.echo_byte  = CH_SP;
                    state_next     = S_BS2;
                end
            end
            S_BS2: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.echo_valid = 1'b1;
                    res.echo_byte  = CH_BS;
                    res_last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (emit) begin
            out_data_reg <= res;
            out_last_reg <= res_last;
        end
    end

    // line storage, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[count_reg[ADDR_W-1:0]] <= head_cmd.ch;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);
    assign m_tlast  = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LINE_LEN))
        else $error("slce_back: line count above line length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> ({1'b0, idx_reg} < (ADDR_W + 1)'(count_reg)))
        else $error("slce_back: hand-off index past stored line");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_cmd.cls == CLS_PRINT && count_reg < CNT_W'(LINE_LEN))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("slce_back: printable byte not counted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && res_last) |=> (state_reg == S_IDLE))
        else $error("slce_back: final result left engine busy");

endmodule

// ===== design/serial_command_line_editor_unit.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_editor_unit
// Line editor for a serial console: echo, backspace, overflow, line hand-off.
// ----------------------------------------------------------------------------
// Each received byte arrives as one transaction on the s_ side and yields
// zero or more result transactions on the m_ side; m_tlast marks the final
// result of a byte. Unused bytes yield no result while the line has room, a
// printable byte or an overflow one result, a backspace on a non-empty line
// three results, and a carriage return 2 + n results for n stored characters
// (at most LINE_LEN + 2), one result per cycle unless m_tready stalls the
// output, from a single output register fed by the line storage read port.
// A four-entry command queue in front takes bytes while a line is handed out.
// ----------------------------------------------------------------------------
module serial_command_line_editor_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] echo_valid, [8:1] echo_byte, [9] line_valid, [16:10] line_byte,
    // [17] line_end, [18] overflow, [23:19] zero
    output logic [slce_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import slce_pkg::*;

    logic  push;
    cmd_t  push_cmd;
    logic  q_full;
    logic  pop;
    logic  head_valid;
    cmd_t  head_cmd;

    slce_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    slce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    slce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
